// File: rtl/pf_pkg.sv
// ----------------------------------------------------------------------------
// pf_pkg: shared types and constants of the prime factorizer
// Widths of the value path, the trial divisor and the serial divider,
// and the request/response bundles between the sequencer and the divider.
// ----------------------------------------------------------------------------
package pf_pkg;

    // Width of the signed input value
    localparam int VALUE_BITS  = 32;
    // Width of the factor result field
    localparam int FACTOR_BITS = 31;
    // Cap on the number of factor beats per input
    localparam int MAX_RESULTS = 31;
    // Trial divisor never exceeds sqrt(2^(VALUE_BITS-1)) plus a step of two
    localparam int DIV_BITS    = VALUE_BITS / 2 + 1;
    // Bit counter of the serial divider
    localparam int CNT_BITS    = $clog2(VALUE_BITS);
    // Beat counter, able to hold MAX_RESULTS itself
    localparam int K_BITS      = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [DIV_BITS-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [DIV_BITS-1:0]   remainder;
    } div_rsp_t;

endpackage

// File: rtl/pf_serdiv.sv
// ----------------------------------------------------------------------------
// pf_serdiv: bit-serial restoring divider
// Produces one quotient bit per cycle; with the last bit the quotient and
// remainder are held and done pulses for one cycle.
// ----------------------------------------------------------------------------
module pf_serdiv
    import pf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [DIV_BITS-1:0]   rem_reg, rem_next;
    logic [DIV_BITS-1:0]   dvs_reg, dvs_next;

    logic [DIV_BITS:0]     rem_sh;
    logic [DIV_BITS+1:0]   diff;
    logic                  ge;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign rem_sh = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign ge     = ~diff[DIV_BITS+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_BITS-2:0], ge};
            rem_next = ge ? diff[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(VALUE_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: rtl/prime_factorizer_unit.sv
// ----------------------------------------------------------------------------
// prime_factorizer_unit: trial-division prime factorizer
// Takes one signed value and emits its prime factors in ascending order.
// ----------------------------------------------------------------------------
// Input channel: value with in_valid / in_stall. A beat is taken when in_valid
// is high and in_stall low; in_stall rises once a beat is accepted and
// stays high until the last factor of that value is in the output register.
// Output channel: factor, negative, no_factor, last with out_valid / out_stall.
// One beat per factor, with multiplicity; last marks the final beat of a value.
// A magnitude of zero or one gives a single beat with factor zero and
// no_factor set. negative is set on every beat of a negative value.
// Each trial divisor (2, then the odd numbers) costs one pass of the
// bit-serial divider and a decision when it is done. A factor found goes
// through ST_EMIT, which loads the output register before the next pass
// starts. A large prime near 2^31 needs about 23200 trials.
// While the receiver stalls, the finished beat holds in the output register
// and the sequencer waits with the next factor; no beat is lost.
// Reset (rst_n low, asynchronous) empties the output register and returns the
// sequencer to idle, ready for a new value.
// ----------------------------------------------------------------------------
module prime_factorizer_unit
    import pf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [FACTOR_BITS-1:0] factor,
    output logic                   negative,
    output logic                   no_factor,
    output logic                   last
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] n_reg, n_next;
    logic [DIV_BITS-1:0]   d_reg, d_next;
    logic [K_BITS-1:0]     k_reg, k_next;
    logic                  neg_reg, neg_next;
    logic [VALUE_BITS-1:0] pend_reg, pend_next;
    logic                  pend_nf_reg, pend_nf_next;
    logic                  pend_last_reg, pend_last_next;

    logic                   out_valid_reg, out_valid_next;
    logic [FACTOR_BITS-1:0] factor_reg, factor_next;
    logic                   negative_reg, negative_next;
    logic                   no_factor_reg, no_factor_next;
    logic                   last_reg, last_next;

    div_req_t              div_req;
    div_rsp_t              div_rsp;

    logic                  in_take;
    logic                  out_free;
    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic                  in_neg;

    pf_serdiv u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Take the magnitude of the incoming value
    assign raw      = VALUE_BITS'(value);
    assign in_neg   = value[VALUE_BITS-1];
    assign mag      = in_neg ? (~raw + 1'b1) : raw;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Sequence trial divisions and factor beats
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        k_next         = k_reg;
        neg_next       = neg_reg;
        pend_next      = pend_reg;
        pend_nf_next   = pend_nf_reg;
        pend_last_next = pend_last_reg;

        div_req.start    = 1'b0;
        div_req.dividend = n_reg;
        div_req.divisor  = d_reg;

        out_valid_next = out_valid_reg && out_stall;
        factor_next    = factor_reg;
        negative_next  = negative_reg;
        no_factor_next = no_factor_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    neg_next = in_neg;
                    k_next   = '0;
                    if ((mag >> 1) == '0)
                    begin
                        pend_next      = '0;
                        pend_nf_next   = 1'b1;
                        pend_last_next = 1'b1;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        n_next           = mag;
                        d_next           = DIV_BITS'(2);
                        div_req.start    = 1'b1;
                        div_req.dividend = mag;
                        div_req.divisor  = DIV_BITS'(2);
                        state_next       = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    pend_nf_next = 1'b0;
                    if (VALUE_BITS'(d_reg) <= div_rsp.quotient)
                    begin
                        if (div_rsp.remainder == '0)
                        begin
                            // Divisible: keep the quotient, report the divisor
                            n_next         = div_rsp.quotient;
                            pend_next      = VALUE_BITS'(d_reg);
                            pend_last_next = (k_reg == K_BITS'(MAX_RESULTS - 1));
                            state_next     = ST_EMIT;
                        end
                        else
                        begin
                            // Advance to the next candidate and divide again
                            d_next = (d_reg == DIV_BITS'(2)) ? DIV_BITS'(3)
                                                             : d_reg + DIV_BITS'(2);
                            div_req.start   = 1'b1;
                            div_req.divisor = d_next;
                        end
                    end
                    else
                    begin
                        // Divisor passed the square root: the rest is prime
                        pend_next      = n_reg;
                        pend_last_next = 1'b1;
                        state_next     = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    factor_next    = FACTOR_BITS'(pend_reg);
                    negative_next  = neg_reg;
                    no_factor_next = pend_nf_reg;
                    last_next      = pend_last_reg;
                    k_next         = k_reg + 1'b1;
                    if (pend_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
        end
    end

    // Working and output payload registers
    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        d_reg         <= d_next;
        neg_reg       <= neg_next;
        pend_reg      <= pend_next;
        pend_nf_reg   <= pend_nf_next;
        pend_last_reg <= pend_last_next;
        factor_reg    <= factor_next;
        negative_reg  <= negative_next;
        no_factor_reg <= no_factor_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign factor    = factor_reg;
    assign negative  = negative_reg;
    assign no_factor = no_factor_reg;
    assign last      = last_reg;

endmodule
